// File: src/lru_key_value_cache_core_macros.svh
// Assertion macros for the cache core files; only lkv_rank uses them.
// Both expect clk and rst_n in the scope where they are used.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LKV_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lkv check failed");
`define LKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkv check failed");
`else
`define LKV_ASSERT(lbl, cond)
`define LKV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/lkv_pkg.sv
package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;
  localparam int CAP_BITS   = 5;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int AGE_W      = IDX_W;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    MODE_GET      = 2'd0,
    MODE_SET      = 2'd1,
    MODE_CONTAINS = 2'd2,
    MODE_REMOVE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_TOUCH,
    RK_DROP,
    RK_INSERT
  } rank_op_t;

  typedef struct packed {
    rank_op_t         op;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] old_slot;
  } rank_cmd_t;

  typedef struct packed {
    logic             key_we;
    logic             val_we;
    logic [IDX_W-1:0] addr;
  } store_wr_t;

endpackage

// File: src/lkv_store.sv
module lkv_store (
  input  logic                          clk,
  input  lkv_pkg::store_wr_t            wr_i,
  input  logic [lkv_pkg::KEY_BITS-1:0]   wr_key_i,
  input  logic [lkv_pkg::VALUE_BITS-1:0] wr_value_i,
  input  logic                          key_re_i,
  input  logic [lkv_pkg::IDX_W-1:0]      key_rd_addr_i,
  input  logic                          val_re_i,
  input  logic [lkv_pkg::IDX_W-1:0]      val_rd_addr_i,
  output logic [lkv_pkg::KEY_BITS-1:0]   rd_key_o,
  output logic [lkv_pkg::VALUE_BITS-1:0] rd_value_o
);
  import lkv_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_value_r;

  always_ff @(posedge clk) begin
    if (wr_i.key_we) begin
      key_mem[wr_i.addr] <= wr_key_i;
    end
    if (key_re_i) begin
      rd_key_r <= key_mem[key_rd_addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.val_we) begin
      val_mem[wr_i.addr] <= wr_value_i;
    end
    if (val_re_i) begin
      rd_value_r <= val_mem[val_rd_addr_i];
    end
  end

  assign rd_key_o   = rd_key_r;
  assign rd_value_o = rd_value_r;

endmodule

// File: src/lkv_rank.sv
`include "lru_key_value_cache_core_macros.svh"

module lkv_rank (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lkv_pkg::rank_cmd_t          cmd_i,
  input  logic [lkv_pkg::CAP_BITS-1:0] capacity_i,
  input  logic [lkv_pkg::IDX_W-1:0]    rd_idx_i,
  output logic                        rd_valid_o,
  output logic [lkv_pkg::AGE_W-1:0]    rd_age_o,
  output logic [lkv_pkg::CNT_W-1:0]    count_o
);
  import lkv_pkg::*;

  localparam int CW = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 1;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [AGE_W-1:0]   age_r [ENTRIES];
  logic [AGE_W-1:0]   age_nxt [ENTRIES];
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [AGE_W-1:0] slot_age;
  logic [CW-1:0]    cnt_p1;
  logic [CW-1:0]    cap_w;
  logic [CW-1:0]    cap_eff;
  logic             full;
  logic             over;

  always_comb begin
    slot_age = age_r[cmd_i.slot];
    cnt_p1   = CW'(count_r) + CW'(1);
    cap_w    = CW'(capacity_i);
    cap_eff  = (cap_w > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_w;
    full     = (count_r == CNT_W'(ENTRIES));
    over     = (cnt_p1 > cap_eff);

    valid_nxt = valid_r;
    age_nxt   = age_r;
    count_nxt = count_r;

    case (cmd_i.op)
      RK_TOUCH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (age_r[i] < slot_age)) begin
            age_nxt[i] = age_r[i] + AGE_W'(1);
          end
        end
        age_nxt[cmd_i.slot] = '0;
      end
      RK_DROP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (age_r[i] > slot_age)) begin
            age_nxt[i] = age_r[i] - AGE_W'(1);
          end
        end
        valid_nxt[cmd_i.slot] = 1'b0;
        age_nxt[cmd_i.slot]   = '0;
        if (count_r != '0) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      RK_INSERT: begin
        // when full, slot is the oldest entry: it is reused, count holds
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i]) begin
            age_nxt[i] = age_r[i] + AGE_W'(1);
          end
        end
        valid_nxt[cmd_i.slot] = 1'b1;
        age_nxt[cmd_i.slot]   = '0;
        if (!full) begin
          count_nxt = count_r + CNT_W'(1);
          if (over) begin
            if (count_r == '0) begin
              // drop the new key at once
              valid_nxt[cmd_i.slot] = 1'b0;
              count_nxt             = '0;
            end else begin
              valid_nxt[cmd_i.old_slot] = 1'b0;
              age_nxt[cmd_i.old_slot]   = '0;
              count_nxt                 = count_r;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      age_r   <= age_nxt;
    end
  end

  assign rd_valid_o = valid_r[rd_idx_i];
  assign rd_age_o   = age_r[rd_idx_i];
  assign count_o    = count_r;

  `LKV_ASSERT(a_count_matches, count_r == CNT_W'($countones(valid_r)))
  `LKV_ASSERT(a_count_bound, count_r <= CNT_W'(ENTRIES))
  `LKV_ASSERT_NEXT(a_touch_front, cmd_i.op == RK_TOUCH,
                   valid_r[$past(cmd_i.slot)] && (age_r[$past(cmd_i.slot)] == '0))

endmodule

// File: src/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement.
// Input channel (in_valid/in_stall): one request word of mode, key and
// write value. Modes: get, set, contains, remove. Result channel
// (out_valid/out_stall): found flag and read value, one word per request.
// Config channel (cfg_valid/cfg_ready): writes the capacity register.
// Each request walks all ENTRIES slots one per cycle through the single
// key compare unit, reading the key memory port; rank and recency are
// then updated in S_ACT. The result word is loaded from S_FIN once the
// output register is free, and the next request is taken in S_IDLE after
// the result is loaded, so only one request is in flight at a time.
// The result sits in an output register; a new request is accepted while
// it waits, and only the load of the following result waits on out_stall.
// Reset clears all valid bits, ranks and the count, and sets capacity to
// 16; key and value memories are not cleared. in_stall is high during
// reset and while a request is in flight.
module lru_key_value_cache_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [lkv_pkg::KEY_BITS-1:0]   in_key,
  input  logic [lkv_pkg::VALUE_BITS-1:0] in_write_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [lkv_pkg::VALUE_BITS-1:0] out_read_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkv_pkg::CAP_BITS-1:0]   cfg_data
);
  import lkv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_LAST,
    S_ACT,
    S_FIN
  } state_t;

  state_t               state_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 cmp_vld_r;
  mode_t                mode_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [VALUE_BITS-1:0] wval_r;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     hit_slot_r, hit_slot_nxt;
  logic                 free_r, free_nxt;
  logic [IDX_W-1:0]     free_slot_r, free_slot_nxt;
  logic                 old_r, old_nxt;
  logic [IDX_W-1:0]     old_slot_r, old_slot_nxt;
  logic [AGE_W-1:0]     old_age_r, old_age_nxt;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [CAP_BITS-1:0]  capacity_r;

  logic                 rd_valid;
  logic [AGE_W-1:0]     rd_age;
  logic [CNT_W-1:0]     count;
  logic [KEY_BITS-1:0]  rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  rank_cmd_t            rank_cmd;
  store_wr_t            store_wr;
  logic [IDX_W-1:0]     ins_slot;
  logic                 in_fire;
  logic                 out_free;

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = rst_n;
  assign ins_slot  = (count == CNT_W'(ENTRIES)) ? old_slot_r : free_slot_r;

  // shared compare: match, first free slot, oldest slot
  always_comb begin
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    free_nxt      = free_r;
    free_slot_nxt = free_slot_r;
    old_nxt       = old_r;
    old_slot_nxt  = old_slot_r;
    old_age_nxt   = old_age_r;
    if (cmp_vld_r) begin
      if (rd_valid && (rd_key == key_r) && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_slot_nxt = cmp_idx_r;
      end
      if (!rd_valid && !free_r) begin
        free_nxt      = 1'b1;
        free_slot_nxt = cmp_idx_r;
      end
      if (rd_valid && (!old_r || (rd_age >= old_age_r))) begin
        old_nxt      = 1'b1;
        old_slot_nxt = cmp_idx_r;
        old_age_nxt  = rd_age;
      end
    end
    // start a fresh search
    if (in_fire) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
      old_nxt  = 1'b0;
    end
  end

  always_comb begin
    rank_cmd = '{op: RK_NONE, slot: hit_slot_r, old_slot: old_slot_r};
    store_wr = '{key_we: 1'b0, val_we: 1'b0, addr: hit_slot_r};
    if (state_r == S_ACT) begin
      unique case (mode_r)
        MODE_GET: begin
          if (hit_r) begin
            rank_cmd.op = RK_TOUCH;
          end
        end
        MODE_SET: begin
          store_wr.val_we = 1'b1;
          if (hit_r) begin
            rank_cmd.op = RK_TOUCH;
          end else begin
            rank_cmd.op     = RK_INSERT;
            rank_cmd.slot   = ins_slot;
            store_wr.key_we = 1'b1;
            store_wr.addr   = ins_slot;
          end
        end
        MODE_CONTAINS: begin
        end
        MODE_REMOVE: begin
          if (hit_r) begin
            rank_cmd.op = RK_DROP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAP_BITS'(16);
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      hit_r       <= hit_nxt;
      hit_slot_r  <= hit_slot_nxt;
      free_r      <= free_nxt;
      free_slot_r <= free_slot_nxt;
      old_r       <= old_nxt;
      old_slot_r  <= old_slot_nxt;
      old_age_r   <= old_age_nxt;
      unique case (state_r)
        S_IDLE: begin
          cmp_vld_r <= 1'b0;
          if (in_fire) begin
            mode_r  <= mode_t'(in_mode);
            key_r   <= in_key;
            wval_r  <= in_write_value;
            idx_r   <= '0;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          cmp_vld_r <= 1'b1;
          cmp_idx_r <= idx_r;
          idx_r     <= idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(ENTRIES - 1)) begin
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          cmp_vld_r <= 1'b0;
          state_r   <= S_ACT;
        end
        S_ACT: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          // hold the result until the previous word is taken
          if (out_free) begin
            out_found_r <= (mode_r == MODE_SET) || hit_r;
            out_value_r <= ((mode_r == MODE_GET) && hit_r) ? rd_value : '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;

  lkv_store u_store (
    .clk           (clk),
    .wr_i          (store_wr),
    .wr_key_i      (key_r),
    .wr_value_i    (wval_r),
    .key_re_i      (state_r == S_SEARCH),
    .key_rd_addr_i (idx_r),
    .val_re_i      (state_r == S_ACT),
    .val_rd_addr_i (hit_slot_r),
    .rd_key_o      (rd_key),
    .rd_value_o    (rd_value)
  );

  lkv_rank u_rank (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (rank_cmd),
    .capacity_i (capacity_r),
    .rd_idx_i   (cmp_idx_r),
    .rd_valid_o (rd_valid),
    .rd_age_o   (rd_age),
    .count_o    (count)
  );

endmodule
